### rtl/ale_pkg.sv
// ale_pkg: sizes, command and status codes, sequencer states and the step
// record shared by the array list engine modules
// no dependencies

package ale_pkg;

   localparam int CAPACITY = 128;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;
   localparam int POS_W    = 8;
   localparam int CMD_W    = 3;
   localparam int STAT_W   = 3;
   localparam int WIDE_W   = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR  = 3'd0,
      CMD_GET    = 3'd1,
      CMD_LOCATE = 3'd2,
      CMD_PRIOR  = 3'd3,
      CMD_NEXT   = 3'd4,
      CMD_INSERT = 3'd5,
      CMD_DELETE = 3'd6
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK           = 3'd0,
      ST_BAD_POS      = 3'd1,
      ST_NOT_FOUND    = 3'd2,
      ST_NO_NEIGHBOUR = 3'd3,
      ST_FULL         = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_SCAN,
      S_NEIGH,
      S_SHIFT
   } state_type;

   // one walk step: next read, pointer update, write-back address, compare
   typedef struct packed {
      logic              issue;
      logic [ADDR_W-1:0] rd_addr;
      logic [CNT_W-1:0]  next_idx;
      logic [ADDR_W-1:0] wr_addr;
      logic              match;
   } step_type;

endpackage

### rtl/ale_ram.sv
// ale_ram: entry store, one write port and one registered read port
// depends on ale_pkg

module ale_ram
   import ale_pkg::*;
(
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              re,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [CAPACITY];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/ale_step.sv
// ale_step: shared walk unit, bound compare, pointer step and key compare
// depends on ale_pkg

module ale_step
   import ale_pkg::*;
(
   input  logic              walk_up,
   input  logic [CNT_W-1:0]  idx,
   input  logic [CNT_W-1:0]  count,
   input  logic [CNT_W-1:0]  stop,
   input  logic [ADDR_W-1:0] didx,
   input  logic [DATA_W-1:0] rd_data,
   input  logic [DATA_W-1:0] key,
   output step_type          step
);

   logic [CNT_W-1:0] idx_dec;

   assign idx_dec = idx - CNT_W'(1);

   always_comb begin
      if (walk_up) begin
         step.issue    = (idx < count);
         step.rd_addr  = ADDR_W'(idx);
         step.next_idx = idx + CNT_W'(1);
         step.wr_addr  = didx - ADDR_W'(1);
      end else begin
         step.issue    = (idx > stop);
         step.rd_addr  = ADDR_W'(idx_dec);
         step.next_idx = idx_dec;
         step.wr_addr  = didx + ADDR_W'(1);
      end
      step.match = (rd_data == key);
   end

endmodule

### rtl/array_list_engine.sv
// array_list_engine: bounded ordered list of signed words, top level with sequencer
// depends on ale_pkg, ale_ram, ale_step
//
// channel   ports                                  transfer
// command   start, busy, req_cmd/position/value    start high while busy low
// result    rsp_strobe, rsp_status/out_value/...   rsp_strobe high, one cycle
//
// clear, errors and unused commands answer in the cycle after the transfer
// get reads the addressed entry, then answers; locate, prior and next walk the list
// insert and delete move the tail
// the single read port of the entry store sets the pace: one entry per cycle
// reset clears the sequencer and the length; the store keeps whatever it holds
// results cannot be stalled: rsp_strobe lasts one cycle and busy falls with it

module array_list_engine
   import ale_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [CMD_W-1:0]         req_cmd,
   input  logic [POS_W-1:0]         req_position,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_strobe,
   output logic [STAT_W-1:0]        rsp_status,
   output logic signed [DATA_W-1:0] rsp_out_value,
   output logic [7:0]               rsp_found_position,
   output logic [7:0]               rsp_count
);

   // sequencer and walk state
   state_type         state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [DATA_W-1:0] key_ff, key_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  stop_ff, stop_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0] didx_ff, didx_in;
   logic              dval_ff, dval_in;
   logic              walk_up_ff, walk_up_in;
   logic [DATA_W-1:0] prev_ff, prev_in;
   logic [DATA_W-1:0] outv_ff, outv_in;

   // result registers
   logic              strobe_ff, strobe_in;
   status_type        status_ff, status_in;
   logic [DATA_W-1:0] value_ff, value_in;
   logic [7:0]        fpos_ff, fpos_in;

   // store ports
   logic              ram_we, ram_re;
   logic [ADDR_W-1:0] ram_wa, ram_ra;
   logic [DATA_W-1:0] ram_wd, rd_data;

   step_type          step;

   // position checks, done in a width that holds both count and position
   logic [WIDE_W-1:0] pos_w, cnt_w;
   logic              get_ok, ins_ok;
   logic [ADDR_W-1:0] pos_idx;
   logic [CNT_W-1:0]  didx_plus;

   ale_ram u_ram (
      .clock   (clock),
      .we      (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .re      (ram_re),
      .rd_addr (ram_ra),
      .rd_data (rd_data)
   );

   ale_step u_step (
      .walk_up (walk_up_ff),
      .idx     (idx_ff),
      .count   (count_ff),
      .stop    (stop_ff),
      .didx    (didx_ff),
      .rd_data (rd_data),
      .key     (key_ff),
      .step    (step)
   );

   assign pos_w     = WIDE_W'(req_position);
   assign cnt_w     = WIDE_W'(count_ff);
   assign get_ok    = (pos_w != '0) && (pos_w <= cnt_w);
   assign ins_ok    = (pos_w != '0) && (pos_w <= cnt_w + WIDE_W'(1));
   assign pos_idx   = ADDR_W'(pos_w - WIDE_W'(1));
   assign didx_plus = CNT_W'(didx_ff) + CNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         dval_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         dval_ff   <= dval_in;
         strobe_ff <= strobe_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      key_ff     <= key_in;
      idx_ff     <= idx_in;
      stop_ff    <= stop_in;
      didx_ff    <= didx_in;
      walk_up_ff <= walk_up_in;
      prev_ff    <= prev_in;
      outv_ff    <= outv_in;
      status_ff  <= status_in;
      value_ff   <= value_in;
      fpos_ff    <= fpos_in;
   end

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      key_in     = key_ff;
      idx_in     = idx_ff;
      stop_in    = stop_ff;
      count_in   = count_ff;
      didx_in    = didx_ff;
      dval_in    = 1'b0;
      walk_up_in = walk_up_ff;
      prev_in    = prev_ff;
      outv_in    = outv_ff;
      strobe_in  = 1'b0;
      status_in  = status_ff;
      value_in   = value_ff;
      fpos_in    = fpos_ff;
      ram_we     = 1'b0;
      ram_wa     = step.wr_addr;
      ram_wd     = rd_data;
      ram_re     = 1'b0;
      ram_ra     = step.rd_addr;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in    = cmd_type'(req_cmd);
               key_in    = req_value;
               // answer now unless an arm below starts a walk
               strobe_in = 1'b1;
               status_in = ST_OK;
               value_in  = '0;
               fpos_in   = '0;
               unique case (cmd_type'(req_cmd))
                  CMD_CLEAR: begin
                     count_in = '0;
                  end
                  CMD_GET: begin
                     if (!get_ok) begin
                        status_in = ST_BAD_POS;
                     end else begin
                        strobe_in = 1'b0;
                        ram_re    = 1'b1;
                        ram_ra    = pos_idx;
                        state_in  = S_READ;
                     end
                  end
                  CMD_LOCATE, CMD_PRIOR, CMD_NEXT: begin
                     strobe_in  = 1'b0;
                     idx_in     = '0;
                     walk_up_in = 1'b1;
                     state_in   = S_SCAN;
                  end
                  CMD_INSERT: begin
                     if (!ins_ok) begin
                        status_in = ST_BAD_POS;
                     end else if (cnt_w >= WIDE_W'(CAPACITY)) begin
                        status_in = ST_FULL;
                     end else begin
                        // walk down from the tail, stop at the insert point
                        strobe_in  = 1'b0;
                        idx_in     = count_ff;
                        stop_in    = CNT_W'(pos_w - WIDE_W'(1));
                        walk_up_in = 1'b0;
                        state_in   = S_SHIFT;
                     end
                  end
                  CMD_DELETE: begin
                     if (!get_ok) begin
                        status_in = ST_BAD_POS;
                     end else begin
                        // fetch the removed entry first, then pull the tail down
                        strobe_in  = 1'b0;
                        ram_re     = 1'b1;
                        ram_ra     = pos_idx;
                        idx_in     = CNT_W'(pos_w);
                        walk_up_in = 1'b1;
                        state_in   = S_READ;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_READ: begin
            if (cmd_ff == CMD_GET) begin
               strobe_in = 1'b1;
               status_in = ST_OK;
               value_in  = rd_data;
               fpos_in   = '0;
               state_in  = S_IDLE;
            end else begin
               outv_in  = rd_data;
               state_in = S_SHIFT;
            end
         end

         S_SCAN: begin
            // read one entry a cycle, compare the entry returned by the previous read
            ram_re  = step.issue;
            dval_in = step.issue;
            if (step.issue) begin
               idx_in  = step.next_idx;
               didx_in = step.rd_addr;
            end
            if (dval_ff) begin
               prev_in = rd_data;
            end
            if (dval_ff && step.match) begin
               strobe_in = 1'b1;
               status_in = ST_OK;
               value_in  = '0;
               fpos_in   = '0;
               state_in  = S_IDLE;
               case (cmd_ff)
                  CMD_LOCATE: begin
                     fpos_in = 8'(didx_plus);
                  end
                  CMD_PRIOR: begin
                     if (didx_ff == '0) begin
                        status_in = ST_NO_NEIGHBOUR;
                     end else begin
                        value_in = prev_ff;
                     end
                  end
                  default: begin
                     if (didx_plus >= count_ff) begin
                        status_in = ST_NO_NEIGHBOUR;
                     end else begin
                        // the entry after the match is being read right now
                        strobe_in = 1'b0;
                        state_in  = S_NEIGH;
                     end
                  end
               endcase
            end else if (!dval_ff && !step.issue) begin
               strobe_in = 1'b1;
               status_in = ST_NOT_FOUND;
               value_in  = '0;
               fpos_in   = '0;
               state_in  = S_IDLE;
            end
         end

         S_NEIGH: begin
            strobe_in = 1'b1;
            status_in = ST_OK;
            value_in  = rd_data;
            fpos_in   = '0;
            state_in  = S_IDLE;
         end

         S_SHIFT: begin
            // move one entry a cycle: read ahead, write back one slot over
            ram_re  = step.issue;
            dval_in = step.issue;
            if (step.issue) begin
               idx_in  = step.next_idx;
               didx_in = step.rd_addr;
            end
            if (dval_ff) begin
               ram_we = 1'b1;
            end
            if (!step.issue && !dval_ff) begin
               strobe_in = 1'b1;
               status_in = ST_OK;
               fpos_in   = '0;
               state_in  = S_IDLE;
               if (walk_up_ff) begin
                  count_in = count_ff - CNT_W'(1);
                  value_in = outv_ff;
               end else begin
                  // gap is open, drop the new word in
                  ram_we   = 1'b1;
                  ram_wa   = ADDR_W'(stop_ff);
                  ram_wd   = key_ff;
                  count_in = count_ff + CNT_W'(1);
                  value_in = '0;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy               = (state_ff != S_IDLE);
   assign rsp_strobe         = strobe_ff;
   assign rsp_status         = status_ff;
   assign rsp_out_value      = value_ff;
   assign rsp_found_position = fpos_ff;
   assign rsp_count          = 8'(count_ff);

   // a result only shows once the sequencer is back at rest
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> (state_ff == S_IDLE))
      else $error("result strobe while sequencer busy");

   // the list never grows past its capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      WIDE_W'(count_ff) <= WIDE_W'(CAPACITY))
      else $error("entry count above capacity");

   // an accepted command either answers at once or keeps the sequencer busy
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || strobe_ff))
      else $error("accepted command dropped");

   // the store is only written while moving entries
   a_write_shift: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_SHIFT))
      else $error("store written outside a shift");

   // length changes only together with a result
   a_count_with_strobe: assert property (@(posedge clock) disable iff (reset)
      (count_in != count_ff) |=> strobe_ff)
      else $error("entry count changed without a result");

endmodule

### tb/array_list_engine_test.sv
// array_list_engine_test: self-checking bench for the array list engine, with a shadow list
// that predicts every answer, directed, capacity and random command traffic
// depends on ale_pkg and array_list_engine

module array_list_engine_test
   import ale_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HALF_PERIOD   = 5;
   localparam int RESET_CYCLES  = 6;
   // leave a wide margin after the last answer for stray strobes
   localparam int SETTLE_CYCLES = 2 * CAPACITY + 50;
   localparam int MAX_IDLE      = 40;

   // cmd code 7 is not decoded by the block
   localparam logic [CMD_W-1:0]  CMD_UNUSED = 3'd7;
   localparam logic signed [DATA_W-1:0] WORD_MIN = {1'b1, {(DATA_W - 1){1'b0}}};
   localparam logic signed [DATA_W-1:0] WORD_MAX = {1'b0, {(DATA_W - 1){1'b1}}};

   // one predicted answer, field by field
   typedef struct {
      status_type                status;
      logic signed [DATA_W-1:0]  out_value;
      logic [7:0]                found_position;
      logic [7:0]                count;
   } list_answer_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic [CMD_W-1:0]          req_cmd = '0;
   logic [POS_W-1:0]          req_position = '0;
   logic signed [DATA_W-1:0]  req_value = '0;
   logic                      rsp_strobe;
   logic [STAT_W-1:0]         rsp_status;
   logic signed [DATA_W-1:0]  rsp_out_value;
   logic [7:0]                rsp_found_position;
   logic [7:0]                rsp_count;

   // shadow copy of the list, updated at each accepted transfer
   logic signed [DATA_W-1:0]  shadow_entries [CAPACITY];
   int                        shadow_count = 0;
   list_answer_type           awaited_answers [$];

   int                        idle_pct = 0;
   int                        fail_count = 0;

   array_list_engine uut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_cmd            (req_cmd),
      .req_position       (req_position),
      .req_value          (req_value),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_out_value      (rsp_out_value),
      .rsp_found_position (rsp_found_position),
      .rsp_count          (rsp_count)
   );

   always #HALF_PERIOD clock = ~clock;

   // run one command against the shadow list and return what the block must answer
   function automatic list_answer_type apply_command(input logic [CMD_W-1:0] op,
                                                     input logic [POS_W-1:0] pos,
                                                     input logic signed [DATA_W-1:0] val);
      list_answer_type ans;
      int p;
      int hit;
      int k;
      p = pos;
      hit = shadow_count;
      ans.status = ST_OK;
      ans.out_value = '0;
      ans.found_position = '0;
      // walking down leaves the first match in hit, full 32-bit compare
      for (k = shadow_count - 1; k >= 0; k--) begin
         if (shadow_entries[k] == val) hit = k;
      end
      case (op)
         CMD_CLEAR: begin
            shadow_count = 0;
         end
         CMD_GET: begin
            if (p < 1 || p > shadow_count) ans.status = ST_BAD_POS;
            else ans.out_value = shadow_entries[p - 1];
         end
         CMD_LOCATE: begin
            if (hit < shadow_count) ans.found_position = 8'(hit + 1);
            else ans.status = ST_NOT_FOUND;
         end
         CMD_PRIOR: begin
            if (hit >= shadow_count) ans.status = ST_NOT_FOUND;
            else if (hit == 0) ans.status = ST_NO_NEIGHBOUR;
            else ans.out_value = shadow_entries[hit - 1];
         end
         CMD_NEXT: begin
            if (hit >= shadow_count) ans.status = ST_NOT_FOUND;
            else if (hit + 1 >= shadow_count) ans.status = ST_NO_NEIGHBOUR;
            else ans.out_value = shadow_entries[hit + 1];
         end
         CMD_INSERT: begin
            // position is judged before the full check
            if (p < 1 || p > shadow_count + 1) begin
               ans.status = ST_BAD_POS;
            end else if (shadow_count >= CAPACITY) begin
               ans.status = ST_FULL;
            end else begin
               for (k = shadow_count; k > p - 1; k--) shadow_entries[k] = shadow_entries[k - 1];
               shadow_entries[p - 1] = val;
               shadow_count++;
            end
         end
         CMD_DELETE: begin
            if (p < 1 || p > shadow_count) begin
               ans.status = ST_BAD_POS;
            end else begin
               ans.out_value = shadow_entries[p - 1];
               for (k = p - 1; k + 1 < shadow_count; k++)
                  shadow_entries[k] = shadow_entries[k + 1];
               shadow_count--;
            end
         end
         default: begin
            // unused code: no change, plain ok
         end
      endcase
      ans.count = shadow_count[7:0];
      return ans;
   endfunction

   // data word: small pool for duplicates, the extremes, or any 32-bit pattern
   function automatic logic signed [DATA_W-1:0] pick_data_value();
      int roll;
      roll = $urandom_range(99);
      if (roll < 40) return DATA_W'(int'($urandom_range(7)) - 3);
      if (roll < 50) begin
         case ($urandom_range(3))
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            2:       return '1;
            default: return '0;
         endcase
      end
      return $urandom;
   endfunction

   // one command transfer: optional idle gap, then hold start until busy is low at an edge
   task automatic send_command(input logic [CMD_W-1:0] op, input int pos,
                               input logic signed [DATA_W-1:0] val);
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < MAX_IDLE && $urandom_range(99) < idle_pct) idle_cycles++;
      if (idle_cycles > 0) begin
         start <= 1'b0;
         repeat (idle_cycles) @(posedge clock);
      end
      start        <= 1'b1;
      req_cmd      <= op;
      req_position <= pos[POS_W-1:0];
      req_value    <= val;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      // transfer taken at this edge, the answer is predicted right away
      awaited_answers.push_back(apply_command(op, pos[POS_W-1:0], val));
   endtask

   // sender holds off until every pending answer has come back
   task automatic wait_for_answers();
      if (start) start <= 1'b0;
      while (awaited_answers.size() != 0) @(posedge clock);
   endtask

   // empty list errors, both extremes, duplicates, list ends, unused code, clear
   task automatic test_directed_cases();
      idle_pct = 12;
      send_command(CMD_GET, 1, '0);
      send_command(CMD_LOCATE, 0, '0);
      send_command(CMD_PRIOR, 0, '0);
      send_command(CMD_NEXT, 0, '0);
      send_command(CMD_DELETE, 1, '0);
      send_command(CMD_INSERT, 0, 32'sd5);
      send_command(CMD_INSERT, 2, 32'sd5);
      send_command(CMD_INSERT, 1, WORD_MAX);
      send_command(CMD_INSERT, 1, WORD_MIN);
      send_command(CMD_INSERT, 3, -32'sd1);
      send_command(CMD_INSERT, 2, 32'sd0);
      // duplicate, so locate must pick the first copy
      send_command(CMD_INSERT, 2, 32'sd0);
      send_command(CMD_LOCATE, 0, 32'sd0);
      send_command(CMD_LOCATE, 0, 32'sd1);
      send_command(CMD_LOCATE, 0, WORD_MAX ^ 32'sd1);
      // neighbours at the list ends and in the middle
      send_command(CMD_PRIOR, 0, WORD_MIN);
      send_command(CMD_NEXT, 0, -32'sd1);
      send_command(CMD_PRIOR, 0, 32'sd0);
      send_command(CMD_NEXT, 0, 32'sd0);
      send_command(CMD_GET, 255, '0);
      send_command(CMD_GET, 5, '0);
      send_command(CMD_UNUSED, 255, '1);
      send_command(CMD_DELETE, 1, '0);
      send_command(CMD_DELETE, 4, '0);
      send_command(CMD_CLEAR, 255, '1);
      wait_for_answers();
   endtask

   // fill to capacity, hit the full case, then drain with worst-case shifts
   task automatic test_capacity_limit();
      int i;
      idle_pct = 12;
      send_command(CMD_CLEAR, 0, '0);
      for (i = 0; i < CAPACITY; i++) begin
         send_command(CMD_INSERT, $urandom_range(shadow_count + 1, 1), pick_data_value());
      end
      send_command(CMD_INSERT, 1, pick_data_value());
      send_command(CMD_INSERT, CAPACITY + 1, pick_data_value());
      // beyond count + 1 the position error wins over full
      send_command(CMD_INSERT, CAPACITY + 2, pick_data_value());
      send_command(CMD_GET, CAPACITY, '0);
      send_command(CMD_GET, CAPACITY + 1, '0);
      send_command(CMD_LOCATE, 0, shadow_entries[CAPACITY - 1]);
      send_command(CMD_NEXT, 0, shadow_entries[CAPACITY - 1]);
      send_command(CMD_PRIOR, 0, shadow_entries[CAPACITY - 1]);
      send_command(CMD_PRIOR, 0, shadow_entries[0]);
      send_command(CMD_DELETE, CAPACITY, '0);
      send_command(CMD_INSERT, CAPACITY / 2, pick_data_value());
      while (shadow_count > 0) send_command(CMD_DELETE, 1, $urandom);
      send_command(CMD_DELETE, 1, '0);
      wait_for_answers();
   endtask

   // mostly well-formed commands on a live list, some noise positions and values
   task automatic test_random_traffic(input int sender_idle_pct, input int n_items);
      int i;
      int roll;
      int pos;
      logic [CMD_W-1:0] op;
      logic signed [DATA_W-1:0] val;
      idle_pct = sender_idle_pct;
      for (i = 0; i < n_items; i++) begin
         roll = $urandom_range(99);
         if (roll < 2) op = CMD_CLEAR;
         else if (roll < 4) op = CMD_UNUSED;
         else if (roll < 34) op = CMD_INSERT;
         else if (roll < 52) op = CMD_DELETE;
         else if (roll < 64) op = CMD_GET;
         else if (roll < 76) op = CMD_LOCATE;
         else if (roll < 88) op = CMD_PRIOR;
         else op = CMD_NEXT;

         // position: valid most of the time, any byte otherwise
         if ($urandom_range(99) < 15) pos = $urandom_range(255);
         else if (op == CMD_INSERT) pos = $urandom_range(shadow_count + 1, 1);
         else if (shadow_count > 0) pos = $urandom_range(shadow_count, 1);
         else pos = $urandom_range(255);

         // search value: stored word, one-bit near miss, or fresh word
         roll = $urandom_range(99);
         if (op != CMD_INSERT && shadow_count > 0 && roll < 55)
            val = shadow_entries[$urandom_range(shadow_count - 1)];
         else if (op != CMD_INSERT && shadow_count > 0 && roll < 70)
            val = shadow_entries[$urandom_range(shadow_count - 1)] ^ (32'sd1 << $urandom_range(31));
         else
            val = pick_data_value();

         send_command(op, pos, val);
         if (i == n_items / 2) wait_for_answers();
      end
      wait_for_answers();
   endtask

   // answer checker: every strobe is matched against the oldest prediction
   always @(posedge clock) begin : check_answers
      list_answer_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (awaited_answers.size() == 0) begin
            $display("%0t: unexpected result, expected none actual status %0d count %0d",
                     $time, rsp_status, rsp_count);
            fail_count++;
         end else begin
            want = awaited_answers.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_status);
               fail_count++;
            end
            if (rsp_out_value !== want.out_value) begin
               $display("%0t: out_value expected %0d actual %0d",
                        $time, want.out_value, rsp_out_value);
               fail_count++;
            end
            if (rsp_found_position !== want.found_position) begin
               $display("%0t: found_position expected %0d actual %0d",
                        $time, want.found_position, rsp_found_position);
               fail_count++;
            end
            if (rsp_count !== want.count) begin
               $display("%0t: count expected %0d actual %0d", $time, want.count, rsp_count);
               fail_count++;
            end
         end
      end
   end

   // test sequence: 12 percent sender idling first, then 85, then none
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_capacity_limit();
      test_random_traffic(12, 450);
      test_random_traffic(85, 450);
      test_random_traffic(0, 450);
      wait_for_answers();
      // room for any stray strobe after the last answer
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("array_list_engine verification clean");
      end else begin
         $display("array_list_engine verification failed");
      end
      $finish;
   end

   // watchdog, far above the slowest legal run
   initial begin
      #20_000_000;
      $display("array_list_engine verification failed");
      $finish;
   end

endmodule
